>>> src/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sblr_pkg.sv
// Constants, types and codes for the spectrum band LED resampler.
package sblr_pkg;

  localparam int BAND_COUNT = 64;
  localparam int MAX_LEDS   = 1023;

  localparam int BAND_AW = $clog2(BAND_COUNT);
  localparam int NB_W    = $clog2(BAND_COUNT + 1);
  localparam int LED_W   = $clog2(MAX_LEDS + 1);

  // field widths
  localparam int BIDX_W = 6;
  localparam int MAG_W  = 16;
  localparam int LIDX_W = 10;
  localparam int MINB_W = 6;
  localparam int MAXB_W = 7;
  localparam int LCNT_W = 10;
  localparam int GAIN_W = 9;
  localparam int LVL_W  = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 10;

  // datapath widths
  localparam int WT_W        = LED_W;
  localparam int DVS_W       = (LED_W > NB_W) ? LED_W : NB_W;
  localparam int SUM_W       = MAG_W + DVS_W;
  localparam int NUM_W       = SUM_W + GAIN_W;
  // level = N / (D * 64 * 256); twice the level needs a shift of 13
  localparam int WHITE_SHIFT = 13;
  localparam int DIV_W       = ((NUM_W - WHITE_SHIFT) > (LIDX_W + NB_W)) ?
                               (NUM_W - WHITE_SHIFT) : (LIDX_W + NB_W);
  localparam int DCNT_W      = $clog2(DIV_W);

  localparam int COL_MAX    = 255;
  localparam int WHITE_BASE = 2 * COL_MAX;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [CFG_AW-1:0] REG_MIN_BAND  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_BAND  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LED_COUNT = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_WHITE_EN  = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> src/sblr_if.sv
// Request and result channel interfaces of the resampler.
interface sblr_in_if;
  import sblr_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BIDX_W-1:0] band_index;
  logic [MAG_W-1:0]  magnitude;
  logic [LIDX_W-1:0] led_index;
  modport source (output valid, cmd, band_index, magnitude, led_index, input ready);
  modport sink (input valid, cmd, band_index, magnitude, led_index, output ready);
endinterface

interface sblr_out_if;
  import sblr_pkg::*;
  logic              valid;
  logic              ready;
  logic [LIDX_W-1:0] led_number;
  logic [LVL_W-1:0]  colour_level;
  logic [LVL_W-1:0]  white_level;
  logic              white_write;
  modport source (output valid, led_number, colour_level, white_level, white_write,
                  input ready);
  modport sink (input valid, led_number, colour_level, white_level, white_write,
                output ready);
endinterface

>>> src/spectrum_band_led_resampler.sv
// Spectrum band to LED resampler top level: band store, walk and level split.
//
//   channel  dir  handshake      carries
//   in_req   in   valid/ready    cmd, band_index, magnitude, led_index
//   out_res  out  valid/ready    led_number, colour_level, white_level, white_write
//   cfg      in   cfg_we only    cfg_idx, cfg_wdata
//
// Band write: the next request is taken in the following cycle.
// Render: W bands are visited (2 when interpolating, up to B/L + 2 when packed),
//   read from the band memory in turn. Two passes of the 22-step shared divider
//   give the band position and then the level.
// Reset clears the control state and the band valid bits and sets the config
//   registers to their defaults; a band never written reads as zero. A stalled result
//   holds in the output register while the block keeps rendering the next request.
module spectrum_band_led_resampler (
  input  logic                        clk,
  input  logic                        rst_n,
  sblr_in_if.sink                     in_req,
  sblr_out_if.source                  out_res,
  input  logic                        cfg_we,
  input  logic [sblr_pkg::CFG_AW-1:0] cfg_idx,
  input  logic [sblr_pkg::CFG_DW-1:0] cfg_wdata
);
  import sblr_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SETUP = 8'b0000_0010,
    ST_DIV1  = 8'b0000_0100,
    ST_WALK  = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_SCALE = 8'b0010_0000,
    ST_DIV2  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  localparam logic [BAND_AW-1:0] LAST_BAND = BAND_AW'(BAND_COUNT - 1);

  // config registers
  logic [MINB_W-1:0] min_band_r;
  logic [MAXB_W-1:0] max_band_r;
  logic [LCNT_W-1:0] led_count_r;
  logic [GAIN_W-1:0] gain_r;
  logic              white_en_r;

  // control and datapath registers
  state_t             state_r, state_nxt;
  logic [LIDX_W-1:0]  led_r, led_nxt;
  logic [BAND_AW-1:0] lo_r, lo_nxt;
  logic [NB_W-1:0]    nb_r, nb_nxt;
  logic [LED_W-1:0]   nl_r, nl_nxt;
  logic               packed_r, packed_nxt;
  logic [BAND_AW-1:0] k_r, k_nxt;
  logic [LED_W-1:0]   off_r, off_nxt;
  logic [NB_W-1:0]    rem_len_r, rem_len_nxt;
  logic               step_r, step_nxt;
  logic [WT_W-1:0]    wt_d_r, wt_d_nxt;
  logic               acc_d_r, acc_d_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DIV_W-1:0]   w_r, w_nxt;

  // output register
  logic               out_vld_r, out_vld_nxt;
  logic [LIDX_W-1:0]  out_led_r, out_led_nxt;
  logic [LVL_W-1:0]   out_col_r, out_col_nxt;
  logic [LVL_W-1:0]   out_wht_r, out_wht_nxt;
  logic               out_ww_r, out_ww_nxt;

  // band store
  logic [MAG_W-1:0]      band_mem [BAND_COUNT];
  logic [BAND_COUNT-1:0] band_vld_r;
  logic [MAG_W-1:0]      mem_q_r;
  logic                  mem_vld_r;
  logic                  wr_en, rd_en;
  logic [BAND_AW-1:0]    wr_addr, rd_addr;

  // combinational helpers
  logic [BAND_AW-1:0]      lo_w;
  logic [NB_W-1:0]         lo_p1_w, hi_w, nb_w;
  logic [LED_W-1:0]        nl_w;
  logic                    render_ok;
  logic [LIDX_W+NB_W-1:0]  t_w;
  logic [LED_W-1:0]        avail_w, ov_w;
  logic [MAG_W-1:0]        mag_eff;
  logic [MAG_W+WT_W-1:0]   prod_w;
  logic [NUM_W-1:0]        num_w;
  logic [LVL_W-1:0]        col_w, wht_w;

  sblr_pkg::div_req_t div_req;
  sblr_pkg::div_rsp_t div_rsp;

  sblr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // window clamps: min below the band count, max at least min+1 and at most the count
  assign lo_w    = (32'(min_band_r) > 32'(BAND_COUNT - 1)) ? LAST_BAND : BAND_AW'(min_band_r);
  assign lo_p1_w = NB_W'(lo_w) + 1'b1;
  assign hi_w    = (32'(max_band_r) < 32'(lo_p1_w)) ? lo_p1_w :
                   (32'(max_band_r) > 32'(BAND_COUNT)) ? NB_W'(BAND_COUNT) :
                   NB_W'(max_band_r);
  assign nb_w    = hi_w - NB_W'(lo_w);
  assign nl_w    = (32'(led_count_r) > 32'(MAX_LEDS)) ? LED_W'(MAX_LEDS) :
                   LED_W'(led_count_r);
  assign render_ok = (nl_w != '0) && (32'(led_r) < 32'(nl_w));
  assign t_w       = led_r * nb_w;

  // packed walk: overlap of the slice with the current band
  assign avail_w = nl_r - off_r;
  assign ov_w    = (32'(avail_w) < 32'(rem_len_r)) ? avail_w : LED_W'(rem_len_r);

  assign mag_eff = mem_vld_r ? mem_q_r : '0;
  assign prod_w  = mag_eff * wt_d_r;
  assign num_w   = sum_r * gain_r;

  // levels: w = floor(2*level); colour = w/2 capped, white = excess over 510 capped
  always_comb begin
    col_w = ((w_r >> 1) > DIV_W'(COL_MAX)) ? LVL_W'(COL_MAX) : LVL_W'(w_r >> 1);
    if (w_r > DIV_W'(WHITE_BASE + COL_MAX)) begin
      wht_w = LVL_W'(COL_MAX);
    end else if (w_r > DIV_W'(WHITE_BASE)) begin
      wht_w = LVL_W'(w_r - DIV_W'(WHITE_BASE));
    end else begin
      wht_w = '0;
    end
  end

  assign wr_addr      = BAND_AW'(in_req.band_index);
  assign in_req.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    led_nxt     = led_r;
    lo_nxt      = lo_r;
    nb_nxt      = nb_r;
    nl_nxt      = nl_r;
    packed_nxt  = packed_r;
    k_nxt       = k_r;
    off_nxt     = off_r;
    rem_len_nxt = rem_len_r;
    step_nxt    = step_r;
    wt_d_nxt    = wt_d_r;
    acc_d_nxt   = 1'b0;
    sum_nxt     = sum_r;
    w_nxt       = w_r;
    out_vld_nxt = out_vld_r;
    out_led_nxt = out_led_r;
    out_col_nxt = out_col_r;
    out_wht_nxt = out_wht_r;
    out_ww_nxt  = out_ww_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = k_r;
    div_req     = '0;

    // accumulate in the cycle after the memory read
    if (acc_d_r) begin
      sum_nxt = sum_r + SUM_W'(prod_w);
    end
    if (out_vld_r && out_res.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          if (in_req.cmd == CMD_WRITE) begin
            wr_en = (32'(in_req.band_index) < 32'(BAND_COUNT));
          end else begin
            led_nxt   = in_req.led_index;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        lo_nxt     = lo_w;
        nb_nxt     = nb_w;
        nl_nxt     = nl_w;
        packed_nxt = (32'(nb_w) > 32'(nl_w));
        if (render_ok) begin
          // floor(led*B/L) and its remainder
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(t_w);
          div_req.divisor  = DVS_W'(nl_w);
          state_nxt        = ST_DIV1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          k_nxt       = lo_r + BAND_AW'(div_rsp.quo);
          off_nxt     = LED_W'(div_rsp.rem);
          rem_len_nxt = nb_r;
          step_nxt    = 1'b0;
          sum_nxt     = '0;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en     = 1'b1;
        acc_d_nxt = 1'b1;
        if (packed_r) begin
          rd_addr     = k_r;
          wt_d_nxt    = ov_w;
          k_nxt       = k_r + 1'b1;
          off_nxt     = '0;
          rem_len_nxt = rem_len_r - NB_W'(ov_w);
          if (32'(rem_len_r) == 32'(ov_w)) begin
            state_nxt = ST_DRAIN;
          end
        end else if (!step_r) begin
          rd_addr  = k_r;
          wt_d_nxt = nl_r - off_r;
          step_nxt = 1'b1;
        end else begin
          // upper neighbor stays on the last band
          rd_addr   = (k_r == LAST_BAND) ? k_r : k_r + 1'b1;
          wt_d_nxt  = off_r;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(num_w >> WHITE_SHIFT);
        div_req.divisor  = packed_r ? DVS_W'(nb_r) : DVS_W'(nl_r);
        state_nxt        = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          w_nxt     = div_rsp.quo;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_res.ready) begin
          out_vld_nxt = 1'b1;
          out_led_nxt = led_r;
          out_col_nxt = col_w;
          out_wht_nxt = white_en_r ? wht_w : '0;
          out_ww_nxt  = white_en_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_d_r     <= 1'b0;
      out_vld_r   <= 1'b0;
      band_vld_r  <= '0;
      min_band_r  <= '0;
      max_band_r  <= MAXB_W'(BAND_COUNT);
      led_count_r <= LCNT_W'(1);
      gain_r      <= GAIN_W'(256);
      white_en_r  <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      acc_d_r   <= acc_d_nxt;
      out_vld_r <= out_vld_nxt;
      if (wr_en) begin
        band_vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_MIN_BAND:  min_band_r  <= cfg_wdata[MINB_W-1:0];
          REG_MAX_BAND:  max_band_r  <= cfg_wdata[MAXB_W-1:0];
          REG_LED_COUNT: led_count_r <= cfg_wdata[LCNT_W-1:0];
          REG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
          REG_WHITE_EN:  white_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    led_r     <= led_nxt;
    lo_r      <= lo_nxt;
    nb_r      <= nb_nxt;
    nl_r      <= nl_nxt;
    packed_r  <= packed_nxt;
    k_r       <= k_nxt;
    off_r     <= off_nxt;
    rem_len_r <= rem_len_nxt;
    step_r    <= step_nxt;
    wt_d_r    <= wt_d_nxt;
    sum_r     <= sum_nxt;
    w_r       <= w_nxt;
    out_led_r <= out_led_nxt;
    out_col_r <= out_col_nxt;
    out_wht_r <= out_wht_nxt;
    out_ww_r  <= out_ww_nxt;
  end

  // band memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      band_mem[wr_addr] <= in_req.magnitude;
    end
    if (rd_en) begin
      mem_q_r   <= band_mem[rd_addr];
      mem_vld_r <= band_vld_r[rd_addr];
    end
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.led_number   = out_led_r;
  assign out_res.colour_level = out_col_r;
  assign out_res.white_level  = out_wht_r;
  assign out_res.white_write  = out_ww_r;

endmodule

>>> src/sblr_div.sv
// Restoring divider, one quotient bit per cycle.
module sblr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  sblr_pkg::div_req_t  req,
  output sblr_pkg::div_rsp_t  rsp
);
  import sblr_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W:0]    shl;
  logic [DVS_W+1:0]  diff;

  assign shl  = {rem_r, quo_r[DIV_W-1]};
  assign diff = {1'b0, shl} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[DVS_W+1]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shl[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> src/sblr_chk.sv
// Port-level checker for the resampler and its bind.
`include "assert_macros.svh"

module sblr_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sblr_pkg::LVL_W-1:0] out_colour_level,
  input logic [sblr_pkg::LVL_W-1:0] out_white_level,
  input logic                       out_white_write
);
  import sblr_pkg::*;

  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_RST(a_white_excess, clk, rst_n, out_valid && out_white_level != '0 |-> out_colour_level == LVL_W'(COL_MAX) && out_white_write, "white without full colour")
  `ASSERT_RST(a_render_busy, clk, rst_n, in_valid && in_ready && in_cmd == CMD_RENDER |=> !in_ready, "render request not held off")
  `ASSERT_RST(a_write_silent, clk, rst_n, in_valid && in_ready && in_cmd == CMD_WRITE && !out_valid |=> !out_valid, "band write made a result")
  `ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind spectrum_band_led_resampler sblr_chk u_sblr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .in_cmd           (in_req.cmd),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_colour_level (out_res.colour_level),
  .out_white_level  (out_res.white_level),
  .out_white_write  (out_res.white_write)
);

>>> dv/sblr_led_checker.sv
// Checker for the resampler: predicts every rendered LED and compares it field by field.
module sblr_led_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  sblr_in_if                          in_ch,
  sblr_out_if                         out_ch,
  input  logic                        cfg_we,
  input  logic [sblr_pkg::CFG_AW-1:0] cfg_idx,
  input  logic [sblr_pkg::CFG_DW-1:0] cfg_wdata,
  output int                          mismatches,
  output int                          results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import sblr_pkg::*;

  typedef struct packed {
    logic [LIDX_W-1:0] led_number;
    logic [LVL_W-1:0]  colour_level;
    logic [LVL_W-1:0]  white_level;
    logic              white_write;
  } led_result_t;

  logic [MAG_W-1:0]  band_mag [BAND_COUNT];
  logic [MINB_W-1:0] win_first;
  logic [MAXB_W-1:0] win_end;
  logic [LCNT_W-1:0] led_total;
  logic [GAIN_W-1:0] fader;
  logic              white_on;

  led_result_t led_due [$];
  int          fail_tally = 0;

  function automatic longint unsigned band_at(input longint unsigned k);
    if (k >= BAND_COUNT) return 0;
    return band_mag[k];
  endfunction

  // Returns 1 and the expected LED when the render request yields a result.
  function automatic bit render_level(input logic [LIDX_W-1:0] led, output led_result_t res);
    longint unsigned lo, hi, nb, nl, a, b, k, s, e, acc, num, den, t, r, x, x1, colour, white;
    res = '0;
    lo = win_first;
    if (lo > BAND_COUNT - 1) lo = BAND_COUNT - 1;
    hi = win_end;
    if (hi < lo + 1) hi = lo + 1;
    if (hi > BAND_COUNT) hi = BAND_COUNT;
    nb = hi - lo;
    nl = led_total;
    if (nl > MAX_LEDS) nl = MAX_LEDS;
    if (nl == 0 || led >= nl) return 1'b0;

    if (nb > nl) begin
      // more bands than LEDs: slice of this LED in 1/L band units, area weighted
      a = lo * nl + led * nb;
      b = a + nb;
      acc = 0;
      for (k = a / nl; k <= (b - 1) / nl; k++) begin
        s = k * nl;
        e = s + nl;
        if (s < a) s = a;
        if (e > b) e = b;
        if (e > s) acc += band_at(k) * (e - s);
      end
      num = acc * fader;
      den = nb * 16384;
    end else begin
      // linear blend of neighbours, upper one held at the last band
      t = led * nb;
      x = lo + t / nl;
      r = t % nl;
      x1 = (x + 1 > BAND_COUNT - 1) ? BAND_COUNT - 1 : x + 1;
      num = (band_at(x) * (nl - r) + band_at(x1) * r) * fader;
      den = nl * 16384;
    end

    if (num <= COL_MAX * den) begin
      colour = num / den;
      white = 0;
    end else begin
      colour = COL_MAX;
      white = (2 * num) / den - WHITE_BASE;
      if (white > COL_MAX) white = COL_MAX;
    end

    res.led_number   = led;
    res.colour_level = colour[LVL_W-1:0];
    res.white_level  = white_on ? white[LVL_W-1:0] : '0;
    res.white_write  = white_on;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    fail_tally++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    led_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < BAND_COUNT; i++) band_mag[i] = '0;
      win_first = '0;
      win_end   = MAXB_W'(BAND_COUNT);
      led_total = LCNT_W'(1);
      fader     = GAIN_W'(256);
      white_on  = 1'b1;
      led_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_BAND:  win_first = cfg_wdata[MINB_W-1:0];
          REG_MAX_BAND:  win_end   = cfg_wdata[MAXB_W-1:0];
          REG_LED_COUNT: led_total = cfg_wdata[LCNT_W-1:0];
          REG_GAIN:      fader     = cfg_wdata[GAIN_W-1:0];
          REG_WHITE_EN:  white_on  = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_WRITE)
          band_mag[in_ch.band_index] = in_ch.magnitude;
        else if (render_level(in_ch.led_index, want))
          led_due.push_back(want);
      end

      if (out_ch.valid && out_ch.ready) begin
        got.led_number   = out_ch.led_number;
        got.colour_level = out_ch.colour_level;
        got.white_level  = out_ch.white_level;
        got.white_write  = out_ch.white_write;
        if (led_due.size() == 0) begin
          flag_mismatch("unexpected result, led_number", got.led_number, 0);
        end else begin
          want = led_due.pop_front();
          if (got.led_number !== want.led_number)
            flag_mismatch("led_number", got.led_number, want.led_number);
          if (got.colour_level !== want.colour_level)
            flag_mismatch("colour_level", got.colour_level, want.colour_level);
          if (got.white_level !== want.white_level)
            flag_mismatch("white_level", got.white_level, want.white_level);
          if (got.white_write !== want.white_write)
            flag_mismatch("white_write", got.white_write, want.white_write);
        end
      end
    end
    mismatches  <= fail_tally;
    results_due <= led_due.size();
  end

endmodule

>>> dv/tb_top.sv
// Testbench top for the resampler: clock, reset, request and config stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sblr_pkg::*;

  // Settle time before a config write or the verdict, since a dropped render
  // gives no result to wait on.
  localparam int unsigned SETTLE_CYCLES   = 200;
  // Cycles with no request or result moving before the run is declared hung.
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 40;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  int          mismatches;
  int          results_due;
  int unsigned idle_cycles = 0;
  int unsigned led_span;     // led_count as last programmed
  bit          burst_mode;   // no gaps between requests in this phase

  sblr_in_if  in_req_if ();
  sblr_out_if out_res_if ();

  spectrum_band_led_resampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req_if),
    .out_res   (out_res_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  sblr_led_checker led_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_req_if),
    .out_ch      (out_res_if),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Gap length shared by both sides: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Magnitudes: the extremes, a band of levels that lands in the colour
  // range at unity gain, and the full 16-bit space for overdrive.
  function automatic logic [MAG_W-1:0] pick_mag();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 55) return MAG_W'($urandom_range(0, 16'h4000));
    return MAG_W'($urandom);
  endfunction

  // LED index: mostly inside the strip, sometimes anywhere (dropped render).
  function automatic logic [LIDX_W-1:0] pick_led();
    if (led_span != 0 && $urandom_range(0, 99) < 88)
      return LIDX_W'($urandom_range(0, led_span - 1));
    return LIDX_W'($urandom_range(0, MAX_LEDS - 1));
  endfunction

  // Present one request and hold it until the block takes it. Valid stays
  // high on return so a back-to-back request needs no second assignment.
  task automatic send_request(input logic cmd, input logic [BIDX_W-1:0] bidx,
                              input logic [MAG_W-1:0] mag, input logic [LIDX_W-1:0] led);
    in_req_if.valid      <= 1'b1;
    in_req_if.cmd        <= cmd;
    in_req_if.band_index <= bidx;
    in_req_if.magnitude  <= mag;
    in_req_if.led_index  <= led;
    do @(posedge clk); while (!in_req_if.ready);
  endtask

  task automatic sender_gap();
    int unsigned g;
    g = burst_mode ? 0 : pick_gap();
    if (g > 0) begin
      in_req_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Unused payload fields carry random bits so every field toggles.
  task automatic write_band(input int unsigned idx, input logic [MAG_W-1:0] mag);
    send_request(CMD_WRITE, BIDX_W'(idx), mag, LIDX_W'($urandom_range(0, MAX_LEDS - 1)));
    sender_gap();
  endtask

  task automatic render_led(input int unsigned led);
    send_request(CMD_RENDER, BIDX_W'($urandom), MAG_W'($urandom), LIDX_W'(led));
    sender_gap();
  endtask

  // Wait for every predicted LED to come back. The count is registered, so
  // look only after an edge has passed.
  task automatic drain_results();
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic quiesce();
    in_req_if.valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across a run of writes; the caller drops it.
  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DW'(val);
    @(posedge clk);
  endtask

  // Reprogram the whole register set once the block has gone idle.
  task automatic program_regs(input int unsigned lo, input int unsigned hi,
                              input int unsigned cnt, input int unsigned g,
                              input int unsigned wen);
    quiesce();
    cfg_write(REG_MIN_BAND, lo);
    cfg_write(REG_MAX_BAND, hi);
    cfg_write(REG_LED_COUNT, cnt);
    cfg_write(REG_GAIN, g);
    cfg_write(REG_WHITE_EN, wen);
    // an index past the last register must leave everything alone
    if ($urandom_range(0, 1))
      cfg_write(REG_WHITE_EN + CFG_AW'($urandom_range(1, 3)), $urandom);
    cfg_we   <= 1'b0;
    led_span = cnt;
  endtask

  // Result side: ready held high for a stretch, sometimes a long one, then
  // dropped for a random gap.
  initial begin
    int unsigned hold, g;
    out_res_if.ready = 1'b0;
    forever begin
      out_res_if.ready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      repeat (hold) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_res_if.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Watchdog: any request or result moving restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_req_if.valid && in_req_if.ready) ||
        (out_res_if.valid && out_res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[spectrum_band_led_resampler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned lo, hi, cnt, g, roll;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_req_if.valid      = 1'b0;
    in_req_if.cmd        = CMD_WRITE;
    in_req_if.band_index = '0;
    in_req_if.magnitude  = '0;
    in_req_if.led_index  = '0;
    led_span             = 1;
    burst_mode           = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // Reset settings: all 64 bands packed into a single LED.
    write_band(0, 16'hFFFF);
    write_band(63, 16'hFFFF);
    write_band(10, 16'h3FC0);        // exactly 255.0 in Q10.6
    write_band(42, 16'h0001);
    render_led(0);
    render_led(1);                   // past the strip: dropped
    render_led(1022);

    // One-band window at the top, min raised past max: upper neighbour clamps.
    program_regs(63, 0, 1023, 256, 1);
    render_led(1022);
    render_led(0);
    render_led(511);

    // Zero LEDs: nothing renders. Gain zero, white off.
    program_regs(0, 64, 0, 0, 0);
    render_led(0);
    write_band(5, 16'h8000);
    write_band(11, 16'h2AAA);

    // Window end past the store, one band per LED, white off with overdrive.
    program_regs(0, 127, 64, 256, 0);
    render_led(63);
    render_led(10);                  // colour exactly at 255, no white
    render_led(0);

    // Two bands into one LED at half gain.
    program_regs(62, 64, 1, 128, 1);
    render_led(0);

    program_regs(0, 64, 2, 256, 1);
    render_led(0);
    render_led(1);

    program_regs(0, 64, 1023, 0, 1);
    render_led(700);

    // --- random phases ---
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      roll = $urandom_range(0, 99);
      lo = (roll < 15) ? 0 : (roll < 25) ? 63 : $urandom_range(0, 63);
      roll = $urandom_range(0, 99);
      hi = (roll < 10) ? 64 : (roll < 15) ? 127 : (roll < 22) ? 0 :
           (roll < 30) ? lo + 1 : $urandom_range(0, 127);
      roll = $urandom_range(0, 99);
      cnt = (roll < 5) ? 0 : (roll < 12) ? MAX_LEDS : (roll < 20) ? 1 :
            (roll < 50) ? $urandom_range(2, 8) : (roll < 80) ? $urandom_range(9, 80) :
            $urandom_range(81, MAX_LEDS - 1);
      roll = $urandom_range(0, 99);
      g = (roll < 15) ? 256 : (roll < 22) ? 0 : $urandom_range(0, 256);
      program_regs(lo, hi, cnt, g, $urandom_range(0, 1));
      burst_mode = ($urandom_range(0, 3) == 0);

      for (int unsigned item = 0; item < ITEMS_PER_PHASE; item++) begin
        if ($urandom_range(0, 99) < 40)
          write_band($urandom_range(0, BAND_COUNT - 1), pick_mag());
        else
          render_led(pick_led());
        // hold the sender back until the block has caught up
        if (item == ITEMS_PER_PHASE / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
          in_req_if.valid <= 1'b0;
          drain_results();
        end
      end
    end

    quiesce();
    if (mismatches == 0 && results_due == 0) begin
      $display("[spectrum_band_led_resampler] OK");
    end else begin
      $display("[spectrum_band_led_resampler] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/sblr_pkg.sv
src/sblr_if.sv
src/sblr_div.sv
src/spectrum_band_led_resampler.sv
src/sblr_chk.sv
dv/sblr_led_checker.sv
dv/tb_top.sv
